FILE: rtl/dfe_pkg.sv
// shared types and constants of the delimiter frame extractor
package dfe_pkg;

  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 3;
  localparam int DELIM_W       = 32;
  localparam int LIMIT_W       = 16;
  localparam int FRAME_LEN_W   = 16;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int PACKED_BYTES  = 4;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEADER_LENGTH  = 3'd0,
    CFG_HEADER_BYTES   = 3'd1,
    CFG_TRAILER_LENGTH = 3'd2,
    CFG_TRAILER_BYTES  = 3'd3,
    CFG_FRAME_LIMIT    = 3'd4
  } cfg_index_t;

  // result status codes
  typedef enum logic {
    STATUS_COMPLETE = 1'b0,
    STATUS_TOO_LONG = 1'b1
  } status_t;

  // register values after reset
  localparam logic [LEN_W-1:0]   RESET_HEADER_LENGTH  = 3'd0;
  localparam logic [DELIM_W-1:0] RESET_HEADER_BYTES   = 32'h0000_0000;
  localparam logic [LEN_W-1:0]   RESET_TRAILER_LENGTH = 3'd2;
  localparam logic [DELIM_W-1:0] RESET_TRAILER_BYTES  = 32'h0000_0A0D;
  localparam logic [LIMIT_W-1:0] RESET_FRAME_LIMIT    = 16'd32;

endpackage

FILE: rtl/dfe_if.sv
// stream, result and configuration channel interfaces of the frame extractor
interface dfe_byte_if;
  logic                         valid;
  logic                         ready;
  logic [dfe_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface dfe_result_if;
  logic                            valid;
  logic                            ready;
  dfe_pkg::status_t                status;
  logic [dfe_pkg::FRAME_LEN_W-1:0] frame_length;

  modport source (output valid, output status, output frame_length, input ready);
  modport sink   (input valid, input status, input frame_length, output ready);
endinterface

interface dfe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dfe_pkg::CFG_INDEX_W-1:0] index;
  logic [dfe_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/delimiter_frame_extractor_top.sv
// delimiter frame extractor: header hunt, trailer match and length limit
// latency: a result is valid in the cycle after the byte that causes it
// throughput: one byte per cycle; the single result register is refilled
//   in the cycle it is taken, so the stream stalls only while it is held
// reset: synchronous; registers return to their defaults, the parser hunts
//   with an empty window and no result is pending
module delimiter_frame_extractor_top #(
  parameter int MAX_DELIM_BYTES = 4,
  parameter int COUNT_BITS      = 16
) (
  input  logic       clk,
  input  logic       rst,
  dfe_byte_if.sink   stream,
  dfe_result_if.source result,
  dfe_cfg_if.sink    cfg
);

  localparam int CAP    = (MAX_DELIM_BYTES < dfe_pkg::PACKED_BYTES) ?
                          MAX_DELIM_BYTES : dfe_pkg::PACKED_BYTES;
  localparam int FILL_W = $clog2(CAP + 1);
  localparam int CMP_W  = (COUNT_BITS > dfe_pkg::LIMIT_W) ? COUNT_BITS : dfe_pkg::LIMIT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic {
    MODE_HUNT,
    MODE_FRAME
  } mode_t;

  typedef logic [CAP-1:0][dfe_pkg::BYTE_W-1:0] window_t;

  // configuration registers
  logic [dfe_pkg::LEN_W-1:0]   header_length;
  logic [dfe_pkg::DELIM_W-1:0] header_bytes;
  logic [dfe_pkg::LEN_W-1:0]   trailer_length;
  logic [dfe_pkg::DELIM_W-1:0] trailer_bytes;
  logic [dfe_pkg::LIMIT_W-1:0] frame_limit;

  // parser state
  mode_t                 mode, mode_next;
  window_t               window, window_next;
  logic [FILL_W-1:0]     fill, fill_next;
  logic [FILL_W-1:0]     matched, matched_next;
  logic [COUNT_BITS-1:0] count, count_next;

  // result register
  logic                            out_valid;
  dfe_pkg::status_t                out_status;
  logic [dfe_pkg::FRAME_LEN_W-1:0] out_length;

  // step results
  logic                            res_valid;
  dfe_pkg::status_t                res_status;
  logic [dfe_pkg::FRAME_LEN_W-1:0] res_length;

  logic take;
  logic [FILL_W-1:0] hlen, tlen;

  // hunt unit signals
  logic              frame_path;
  window_t           hunt_win, hunt_shift;
  logic [FILL_W-1:0] hunt_fill, hunt_fill_new;
  logic              hunt_hit;

  // frame path signals
  logic [COUNT_BITS-1:0] f_count, f_count_inc;
  logic [FILL_W-1:0]     f_matched, m_eff;
  logic [CMP_W-1:0]      count_ext, limit_ext, inc_ext;
  logic [dfe_pkg::BYTE_W-1:0] trailer_sel;

  // handshakes
  assign cfg.ready    = 1'b1;
  assign stream.ready = !out_valid || result.ready;
  assign take         = stream.valid && stream.ready;

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.frame_length = out_length;

  // effective delimiter lengths, capped at the window size
  assign hlen = (header_length > dfe_pkg::LEN_W'(CAP)) ? FILL_W'(CAP) : FILL_W'(header_length);
  assign tlen = (trailer_length > dfe_pkg::LEN_W'(CAP)) ? FILL_W'(CAP) : FILL_W'(trailer_length);

  // a byte is handled by the frame path when in a frame or with no header
  assign frame_path = (mode == MODE_FRAME) || (hlen == '0);
  assign f_count    = (mode == MODE_FRAME) ? count : '0;
  assign f_matched  = (mode == MODE_FRAME) ? matched : '0;

  // hunt unit: shared by plain hunting and the restart after a too-long frame
  assign hunt_win  = frame_path ? '0 : window;
  assign hunt_fill = frame_path ? '0 : fill;

  always_comb begin
    hunt_shift    = hunt_win;
    hunt_shift[0] = stream.data_byte;
    for (int k = 1; k < CAP; k++) begin
      hunt_shift[k] = hunt_win[k-1];
    end
    hunt_fill_new = (hunt_fill < FILL_W'(CAP)) ? hunt_fill + 1'b1 : hunt_fill;
    hunt_hit      = (hlen != '0) && (hunt_fill_new >= hlen);
    // header byte i lines up with window byte hlen-1-i
    for (int i = 0; i < CAP; i++) begin
      for (int j = 0; j < CAP; j++) begin
        if ((i + j + 1 == int'(hlen)) &&
            (header_bytes[i*dfe_pkg::BYTE_W +: dfe_pkg::BYTE_W] != hunt_shift[j])) begin
          hunt_hit = 1'b0;
        end
      end
    end
  end

  // trailer byte selected by the match position
  assign m_eff = (f_matched >= tlen) ? '0 : f_matched;

  always_comb begin
    trailer_sel = trailer_bytes[dfe_pkg::BYTE_W-1:0];
    for (int k = 0; k < CAP; k++) begin
      if (m_eff == FILL_W'(k)) begin
        trailer_sel = trailer_bytes[k*dfe_pkg::BYTE_W +: dfe_pkg::BYTE_W];
      end
    end
  end

  // byte counter with saturation
  assign f_count_inc = (f_count == COUNT_MAX) ? f_count : f_count + 1'b1;
  assign count_ext   = CMP_W'(f_count);
  assign inc_ext     = CMP_W'(f_count_inc);
  assign limit_ext   = CMP_W'(frame_limit);

  // next parser state and result of one byte
  always_comb begin
    mode_next    = mode;
    window_next  = window;
    fill_next    = fill;
    matched_next = matched;
    count_next   = count;
    res_valid    = 1'b0;
    res_status   = dfe_pkg::STATUS_COMPLETE;
    res_length   = inc_ext[dfe_pkg::FRAME_LEN_W-1:0];

    if (!frame_path || (tlen != '0 && count_ext >= limit_ext)) begin
      if (frame_path) begin
        // too long: report, then hunt again with this byte
        res_valid  = 1'b1;
        res_status = dfe_pkg::STATUS_TOO_LONG;
        res_length = count_ext[dfe_pkg::FRAME_LEN_W-1:0];
      end
      if (hunt_hit) begin
        mode_next    = MODE_FRAME;
        count_next   = COUNT_BITS'(hlen);
        matched_next = '0;
        window_next  = '0;
        fill_next    = '0;
      end else if (hlen != '0) begin
        mode_next    = MODE_HUNT;
        count_next   = '0;
        matched_next = '0;
        window_next  = hunt_shift;
        fill_next    = hunt_fill_new;
      end else begin
        mode_next    = MODE_HUNT;
        count_next   = '0;
        matched_next = '0;
        window_next  = '0;
        fill_next    = '0;
      end
    end else begin
      mode_next   = MODE_FRAME;
      window_next = '0;
      fill_next   = '0;
      if (tlen == '0) begin
        // no trailer: bytes are ignored
        count_next   = f_count;
        matched_next = f_matched;
      end else if (stream.data_byte == trailer_sel) begin
        if (m_eff + 1'b1 == tlen) begin
          res_valid    = 1'b1;
          mode_next    = MODE_HUNT;
          count_next   = '0;
          matched_next = '0;
        end else begin
          count_next   = f_count_inc;
          matched_next = m_eff + 1'b1;
        end
      end else if (stream.data_byte == trailer_bytes[dfe_pkg::BYTE_W-1:0]) begin
        count_next   = f_count_inc;
        matched_next = FILL_W'(1);
      end else begin
        count_next   = f_count_inc;
        matched_next = '0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_length  <= dfe_pkg::RESET_HEADER_LENGTH;
      header_bytes   <= dfe_pkg::RESET_HEADER_BYTES;
      trailer_length <= dfe_pkg::RESET_TRAILER_LENGTH;
      trailer_bytes  <= dfe_pkg::RESET_TRAILER_BYTES;
      frame_limit    <= dfe_pkg::RESET_FRAME_LIMIT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        dfe_pkg::CFG_HEADER_LENGTH:  header_length  <= cfg.data[dfe_pkg::LEN_W-1:0];
        dfe_pkg::CFG_HEADER_BYTES:   header_bytes   <= cfg.data[dfe_pkg::DELIM_W-1:0];
        dfe_pkg::CFG_TRAILER_LENGTH: trailer_length <= cfg.data[dfe_pkg::LEN_W-1:0];
        dfe_pkg::CFG_TRAILER_BYTES:  trailer_bytes  <= cfg.data[dfe_pkg::DELIM_W-1:0];
        dfe_pkg::CFG_FRAME_LIMIT:    frame_limit    <= cfg.data[dfe_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_HUNT;
      window    <= '0;
      fill      <= '0;
      matched   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        mode    <= mode_next;
        window  <= window_next;
        fill    <= fill_next;
        matched <= matched_next;
        count   <= count_next;
      end
      if (stream.ready) begin
        out_valid <= take && res_valid;
      end
    end
    if (take && res_valid) begin
      out_status <= res_status;
      out_length <= res_length;
    end
  end

  // a completed frame always sends the parser back to hunting
  a_complete_hunts: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && res_status == dfe_pkg::STATUS_COMPLETE) |=> (mode == MODE_HUNT))
    else $error("parser not hunting after a complete frame");

  // the window never holds more bytes than it has room for
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(CAP))
    else $error("window fill above capacity");

  // inside a frame the hunting window stays empty
  a_frame_window_empty: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_FRAME) |-> (fill == '0 && window == '0))
    else $error("window not empty inside a frame");

  // a pending result stays put while the stream is stalled
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> (out_valid && $stable(out_length)))
    else $error("pending result changed while stalled");

endmodule

FILE: tb/tb_checker.sv
// frame extractor checker: watches the channels, predicts results and compares them
module tb_checker #(
  parameter int MAX_DELIM_BYTES = 4,
  parameter int COUNT_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  dfe_byte_if         stream,
  dfe_result_if       result,
  dfe_cfg_if          cfg,
  output int unsigned fail_count,
  output int unsigned pending
);
  import dfe_pkg::*;

  typedef enum logic [1:0] {
    HUNTING    = 2'd0,
    FRAME_BODY = 2'd1
  } parse_mode_t;

  typedef struct packed {
    status_t                  status;
    logic [FRAME_LEN_W-1:0]   frame_length;
  } frame_result_t;

  // shadow copy of the registers
  logic [LEN_W-1:0]    hdr_len;
  logic [DELIM_W-1:0]  hdr_pattern;
  logic [LEN_W-1:0]    trl_len;
  logic [DELIM_W-1:0]  trl_pattern;
  logic [LIMIT_W-1:0]  limit_reg;

  // parser state
  parse_mode_t           mode;
  logic [DELIM_W-1:0]    window;
  logic [2:0]            window_fill;
  logic [2:0]            trl_hits;
  logic [COUNT_BITS-1:0] count;

  frame_result_t expected_frames[$];

  // lengths beyond the supported delimiter size are clipped
  function automatic logic [2:0] clip_len(input logic [LEN_W-1:0] len);
    int unsigned cap;
    cap = (MAX_DELIM_BYTES < 4) ? MAX_DELIM_BYTES : 4;
    return (len > cap) ? 3'(cap) : len;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte(input logic [DELIM_W-1:0] word,
                                                  input int unsigned pos);
    return word[8*(pos%4) +: 8];
  endfunction

  task automatic restart_hunt();
    mode        = HUNTING;
    window      = '0;
    window_fill = '0;
    trl_hits    = '0;
    count       = '0;
  endtask

  // slide the byte into the window and look for the header
  task automatic shift_into_window(input logic [BYTE_W-1:0] b);
    logic [2:0]  hlen;
    bit          hit;
    int unsigned i;
    hlen   = clip_len(hdr_len);
    hit    = 1'b1;
    window = {window[DELIM_W-9:0], b};
    if (window_fill < 3'd4) window_fill++;
    if (hlen == 0 || window_fill < hlen) return;
    for (i = 0; i < hlen; i++) begin
      if (pick_byte(hdr_pattern, i) != pick_byte(window, hlen - 1 - i)) hit = 1'b0;
    end
    if (hit) begin
      mode        = FRAME_BODY;
      count       = COUNT_BITS'(hlen);
      trl_hits    = '0;
      window      = '0;
      window_fill = '0;
    end
  endtask

  // expected outcome of one accepted byte
  task automatic predict_byte(input logic [BYTE_W-1:0] b, output bit produced,
                              output frame_result_t res);
    logic [2:0] tlen;
    produced         = 1'b0;
    res.status       = STATUS_COMPLETE;
    res.frame_length = '0;
    if (mode != FRAME_BODY) begin
      if (clip_len(hdr_len) != 0) begin
        mode = HUNTING;
        shift_into_window(b);
        return;
      end
      mode        = FRAME_BODY;
      count       = '0;
      trl_hits    = '0;
      window      = '0;
      window_fill = '0;
    end
    tlen = clip_len(trl_len);
    if (tlen == 0) return;
    // byte arriving at the limit: too long, and it may open the next header
    if (count >= limit_reg) begin
      produced         = 1'b1;
      res.status       = STATUS_TOO_LONG;
      res.frame_length = FRAME_LEN_W'(count);
      restart_hunt();
      if (clip_len(hdr_len) != 0) shift_into_window(b);
      return;
    end
    if (count != {COUNT_BITS{1'b1}}) count++;
    if (trl_hits >= tlen) trl_hits = '0;
    if (b == pick_byte(trl_pattern, trl_hits)) begin
      trl_hits++;
      if (trl_hits == tlen) begin
        produced         = 1'b1;
        res.status       = STATUS_COMPLETE;
        res.frame_length = FRAME_LEN_W'(count);
        restart_hunt();
      end
    end else if (b == pick_byte(trl_pattern, 0)) begin
      trl_hits = 3'd1;
    end else begin
      trl_hits = '0;
    end
  endtask

  task automatic flag_mismatch(input string detail);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, detail);
  endtask

  // result transactions first, then the byte, then register writes
  always @(posedge clk) begin : monitor
    frame_result_t want;
    frame_result_t got;
    bit            produced;
    if (rst) begin
      hdr_len     = RESET_HEADER_LENGTH;
      hdr_pattern = RESET_HEADER_BYTES;
      trl_len     = RESET_TRAILER_LENGTH;
      trl_pattern = RESET_TRAILER_BYTES;
      limit_reg   = RESET_FRAME_LIMIT;
      restart_hunt();
      expected_frames.delete();
      fail_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        got.status       = result.status;
        got.frame_length = result.frame_length;
        if (expected_frames.size() == 0) begin
          flag_mismatch($sformatf("result with none expected, status %0d length %0d",
                                  got.status, got.frame_length));
        end else begin
          want = expected_frames.pop_front();
          if (got.status !== want.status) begin
            flag_mismatch($sformatf("status expected %0d got %0d", want.status, got.status));
          end
          if (got.frame_length !== want.frame_length) begin
            flag_mismatch($sformatf("frame_length expected %0d got %0d",
                                    want.frame_length, got.frame_length));
          end
        end
      end
      if (stream.valid && stream.ready) begin
        predict_byte(stream.data_byte, produced, want);
        if (produced) expected_frames.push_back(want);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_HEADER_LENGTH:  hdr_len     = cfg.data[LEN_W-1:0];
          CFG_HEADER_BYTES:   hdr_pattern = cfg.data[DELIM_W-1:0];
          CFG_TRAILER_LENGTH: trl_len     = cfg.data[LEN_W-1:0];
          CFG_TRAILER_BYTES:  trl_pattern = cfg.data[DELIM_W-1:0];
          CFG_FRAME_LIMIT:    limit_reg   = cfg.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_frames.size();
  end

endmodule

FILE: tb/tb_top.sv
// frame extractor testbench top: clock, reset, stimulus and verdict
module tb_top;
  import dfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_LEN    = 150;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_cycles  = 0;
  logic        hold_request = 1'b0;

  // register values as last programmed, used to build frames
  logic [LEN_W-1:0]   cur_hlen  = RESET_HEADER_LENGTH;
  logic [DELIM_W-1:0] cur_hdr   = RESET_HEADER_BYTES;
  logic [LEN_W-1:0]   cur_tlen  = RESET_TRAILER_LENGTH;
  logic [DELIM_W-1:0] cur_trl   = RESET_TRAILER_BYTES;
  logic [LIMIT_W-1:0] cur_limit = RESET_FRAME_LIMIT;

  dfe_byte_if   stream ();
  dfe_result_if result ();
  dfe_cfg_if    cfg ();

  delimiter_frame_extractor_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .result (result),
    .cfg    (cfg)
  );

  tb_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .result     (result),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock, period 12
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_request) begin
      hold_cycles <= HOLD_LEN;
    end
  end

  // result receiver with random stalls
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= (hold_cycles == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // one byte transaction, with random idle cycles in front
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      stream.valid <= 1'b0;
      @(posedge clk);
    end
    stream.valid     <= 1'b1;
    stream.data_byte <= b;
    do begin
      @(posedge clk);
    end while (!stream.ready);
  endtask

  // first n bytes of a packed word, lowest byte first
  task automatic send_word(input logic [DELIM_W-1:0] word, input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_byte(word[8*k +: 8]);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg.ready);
  endtask

  // all five registers; unused upper data bits carry noise
  task automatic program_regs(input logic [LEN_W-1:0] hl, input logic [DELIM_W-1:0] hb,
                              input logic [LEN_W-1:0] tl, input logic [DELIM_W-1:0] tb,
                              input logic [LIMIT_W-1:0] lim);
    write_reg(CFG_HEADER_LENGTH, CFG_DATA_W'({$urandom(), hl}));
    write_reg(CFG_HEADER_BYTES, hb);
    write_reg(CFG_TRAILER_LENGTH, CFG_DATA_W'({$urandom(), tl}));
    write_reg(CFG_TRAILER_BYTES, tb);
    write_reg(CFG_FRAME_LIMIT, CFG_DATA_W'({$urandom(), lim}));
    cfg.valid <= 1'b0;
    cur_hlen  = hl;
    cur_hdr   = hb;
    cur_tlen  = tl;
    cur_trl   = tb;
    cur_limit = lim;
  endtask

  // stop sending, wait for every result, then let the pipeline empty
  task automatic settle();
    stream.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // payload byte biased towards delimiter bytes
  function automatic logic [BYTE_W-1:0] body_byte(input int unsigned tl);
    int unsigned pick;
    pick = $urandom_range(99);
    if (tl != 0 && pick < 30) return cur_trl[8*$urandom_range(tl - 1) +: 8];
    if (pick < 40) return cur_hdr[8*$urandom_range(3) +: 8];
    return BYTE_W'($urandom());
  endfunction

  // mostly well-formed frames, some noise and broken frames
  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned hl;
    int unsigned tl;
    int unsigned body;
    int unsigned span;
    int unsigned pick;
    int unsigned k;
    int unsigned hn;
    int unsigned tn;
    sent = 0;
    hl   = (cur_hlen > 4) ? 4 : cur_hlen;
    tl   = (cur_tlen > 4) ? 4 : cur_tlen;
    span = (cur_limit < 40) ? cur_limit : 40;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // complete frame, now and then past the limit
        if (cur_limit <= 64 && $urandom_range(4) == 0) begin
          body = cur_limit + $urandom_range(2);
        end else begin
          body = $urandom_range(span);
        end
        send_word(cur_hdr, hl);
        for (k = 0; k < body; k++) send_byte(body_byte(tl));
        send_word(cur_trl, tl);
        sent += hl + body + tl;
      end else if (pick < 85) begin
        // line noise
        body = $urandom_range(6, 1);
        for (k = 0; k < body; k++) send_byte(BYTE_W'($urandom()));
        sent += body;
      end else begin
        // truncated header or truncated trailer
        body = $urandom_range(4);
        hn   = $urandom_range(hl);
        tn   = (tl == 0) ? 0 : $urandom_range(tl - 1);
        send_word(cur_hdr, hn);
        for (k = 0; k < body; k++) send_byte(body_byte(tl));
        send_word(cur_trl, tn);
        sent += hn + body + tn;
      end
    end
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] hl, input logic [DELIM_W-1:0] hb,
                           input logic [LEN_W-1:0] tl, input logic [DELIM_W-1:0] tb,
                           input logic [LIMIT_W-1:0] lim, input int unsigned idle,
                           input int unsigned stall, input int unsigned n_items);
    settle();
    program_regs(hl, hb, tl, tb, lim);
    idle_pct  = idle;
    stall_pct = stall;
    run_traffic(n_items);
  endtask

  initial begin
    logic [DELIM_W-1:0] rep;
    int unsigned        r;
    rst              <= 1'b1;
    stream.valid     <= 1'b0;
    stream.data_byte <= '0;
    cfg.valid        <= 1'b0;
    cfg.index        <= CFG_HEADER_LENGTH;
    cfg.data         <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset registers: trailer match restarts on a repeated first byte
    send_word(32'h0D0D_FF00, 4);
    send_byte(8'h0A);

    // oversized lengths clip to four; zero limit makes the next byte too long
    settle();
    program_regs(3'd7, 32'h0403_0201, 3'd6, 32'h0A0D_0A0D, 16'd0);
    send_word(32'h0403_0201, 4);
    send_byte(8'h55);

    // partial trailer match goes stale when the trailer is shortened
    settle();
    program_regs(3'd0, 32'hFFFF_FFFF, 3'd4, 32'h4433_2211, 16'hFFFF);
    send_word(32'h0033_2211, 3);
    settle();
    program_regs(3'd0, 32'hFFFF_FFFF, 3'd2, 32'h4433_2211, 16'hFFFF);
    send_word(32'h0000_2211, 2);

    // no trailer: bytes are swallowed until one is set
    settle();
    program_regs(3'd0, 32'h0000_0000, 3'd0, 32'h0000_00AA, 16'd32);
    send_word(32'hFFAA_00FF, 4);
    settle();
    program_regs(3'd0, 32'h0000_0000, 3'd1, 32'h0000_00AA, 16'd32);
    send_byte(8'hAA);

    // no header, no idling, then a long receiver hold-off
    run_phase(3'd0, $urandom(), 3'd2, 32'h0000_0A0D, 16'd32, 0, 0, 100);
    stream.valid <= 1'b0;
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    run_traffic(120);

    // full header and trailer, largest limit, sender idling with a full pause
    run_phase(3'd4, $urandom(), 3'd4, $urandom(), 16'hFFFF, 74, 0, 100);
    settle();
    run_traffic(100);

    // single-byte delimiters, frame limit of one, receiver stalling
    run_phase(3'd1, 32'hFFFF_FFFF, 3'd1, $urandom(), 16'd1, 0, 74, 200);

    // trailer with a repeated first byte, both sides idling
    rep = $urandom();
    rep[15:8] = rep[7:0];
    run_phase(3'd2, $urandom(), 3'd3, rep, LIMIT_W'($urandom_range(40, 8)), 31, 31, 200);

    // no trailer after a header
    run_phase(3'd3, $urandom(), 3'd0, $urandom(), 16'd20, 0, 0, 60);

    // oversized lengths under traffic
    run_phase(3'd5, $urandom(), 3'd7, $urandom(), LIMIT_W'($urandom_range(60, 1)),
              74, 0, 200);

    // all-zero trailer, receiver stalling
    run_phase(3'd0, $urandom(), 3'd4, 32'h0000_0000, LIMIT_W'($urandom_range(60, 1)),
              0, 74, 200);

    // random settings
    for (r = 0; r < 3; r++) begin
      rep = $urandom();
      if ($urandom_range(1) != 0) rep[15:8] = rep[7:0];
      run_phase(LEN_W'($urandom_range(7)), $urandom(), LEN_W'($urandom_range(7, 1)), rep,
                LIMIT_W'($urandom_range(48, 1)), (r == 1) ? 74 : 31, (r == 2) ? 74 : 31, 150);
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
